// ----- hdl/i2c_master_register_access_defines.svh -----
// Assertion macros used by the checker file of the I2C register-access master.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// Concurrent check on the block clock, switched off while reset is held.
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check on the block clock that also holds across reset.
`define I2CM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/i2cm_pkg.sv -----
// Types and constants shared by the I2C register-access master modules.
`default_nettype none

package i2cm_pkg;

    localparam int LEN_W     = 5;
    localparam int BYTE_BITS = 8;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_START_FAIL = 2'd1;
    localparam logic [1:0] ST_NACK       = 2'd2;

    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    typedef struct packed {
        logic [1:0]       command;
        logic             sda_in;
        logic [6:0]       dev_addr;
        logic [7:0]       reg_addr;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_LOAD,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             sda_in;
        logic [6:0]       dev_addr;
        logic [7:0]       reg_addr;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
    } t_q_item;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SEND,
        PH_WACK,
        PH_RECV,
        PH_MACK,
        PH_STOP
    } t_phase;

    typedef enum logic [2:0] {
        SG_START1,
        SG_ADDRW,
        SG_REG,
        SG_DATA,
        SG_START2,
        SG_ADDRR
    } t_stage;

    typedef enum logic [2:0] {
        ACT_STEP,
        ACT_SEND,
        ACT_STOP,
        ACT_RECV,
        ACT_RESTART,
        ACT_FAIL,
        ACT_FINISH
    } t_act;

endpackage

`default_nettype wire

// ----- hdl/i2c_master_register_access.sv -----
// Top level of the I2C register-access master: decoder, command queue and bus engine.
// Throughput: one transaction per cycle while the output is not stalled; the bus engine
// retires one queue entry per cycle. The two-entry queue absorbs output stalls, so input
// stall follows only a full queue.
// Reset (synchronous, active low) idles the engine, releases SCL and SDA and empties
// the queue and the write-byte count; buffer contents are not cleared.
`default_nettype none

module i2c_master_register_access #(
    parameter int BUF_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  i2cm_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cm_pkg::t_out_item o_out
);
    import i2cm_pkg::*;

    t_q_item front_item;
    t_q_item q_item;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;

    i2cm_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_in   (i_in),
        .o_item (front_item)
    );

    i2cm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    i2cm_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    assign o_in_stall = q_full;

endmodule

`default_nettype wire

// ----- hdl/i2cm_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none

module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/i2cm_front.sv -----
// Front end: decodes incoming commands into queue entries and clamps write lengths.
`default_nettype none

module i2cm_front #(
    parameter int BUF_DEPTH = 16
) (
    input  i2cm_pkg::t_in_item i_in,
    output i2cm_pkg::t_q_item  o_item
);
    import i2cm_pkg::*;

    always_comb begin
        o_item.sda_in   = i_in.sda_in;
        o_item.dev_addr = i_in.dev_addr;
        o_item.reg_addr = i_in.reg_addr;
        o_item.length   = i_in.length;
        o_item.data     = i_in.data;
        case (i_in.command)
            CMD_TICK:  o_item.op = OP_TICK;
            CMD_LOAD:  o_item.op = OP_LOAD;
            CMD_WRITE: o_item.op = OP_WRITE;
            CMD_READ:  o_item.op = OP_READ;
            default:   o_item.op = OP_TICK;
        endcase
        if ((i_in.command == CMD_WRITE) && (int'(i_in.length) > BUF_DEPTH)) begin
            o_item.length = LEN_W'(BUF_DEPTH);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2cm_fifo.sv -----
// Two-entry queue between the command decoder and the bus engine.
`default_nettype none

module i2cm_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cm_pkg::t_q_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output i2cm_pkg::t_q_item o_item,
    input  logic              i_pop
);
    import i2cm_pkg::*;

    t_q_item              r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 push_ok;
    logic                 pop_ok;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2cm_back.sv -----
// Bus engine: runs the I2C phase sequencer one delay period per tick and registers results.
`default_nettype none

module i2cm_back #(
    parameter int BUF_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  i2cm_pkg::t_q_item   i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cm_pkg::t_out_item o_out
);
    import i2cm_pkg::*;

    localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_sub, n_sub;
    t_stage           r_stage, n_stage;
    logic [1:0]       r_pend, n_pend;
    logic [3:0]       r_bit_cnt, n_bit_cnt;
    logic [7:0]       r_shift, n_shift;
    logic [LEN_W-1:0] r_byte_idx, n_byte_idx;
    logic [LEN_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [6:0]       r_taddr, n_taddr;
    logic [7:0]       r_treg, n_treg;
    logic             r_is_read, n_is_read;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic             r_out_valid;
    t_out_item        r_out, n_out;

    logic             pop;
    logic             busy;
    logic             sda;
    logic             do_tick;
    logic             do_begin;
    logic             do_load;
    logic [LEN_W-1:0] left_dec;
    logic [LEN_W-1:0] idx_inc;
    logic [3:0]       bc_inc;
    logic             more_now;
    logic             more_next;
    logic [7:0]       addr_w;
    logic [7:0]       addr_r;
    logic [7:0]       shift_in;
    logic [7:0]       rd_data;
    logic [AW-1:0]    rd_addr;

    t_act             act;
    logic [7:0]       act_val;
    t_stage           act_stage;
    logic [1:0]       act_code;
    logic             adv_data;
    logic             rx_val;

    assign pop      = i_q_valid && (!r_out_valid || !i_out_stall);
    assign busy     = (r_phase != PH_IDLE);
    assign sda      = i_q_item.sda_in;
    assign do_tick  = pop && (i_q_item.op == OP_TICK) && busy;
    assign do_begin = pop && ((i_q_item.op == OP_WRITE) || (i_q_item.op == OP_READ)) && !busy;
    assign do_load  = pop && (i_q_item.op == OP_LOAD) && !busy && (int'(r_fill) < BUF_DEPTH);

    assign left_dec  = r_left - 1'b1;
    assign idx_inc   = r_byte_idx + 1'b1;
    assign bc_inc    = r_bit_cnt + 1'b1;
    assign more_now  = (r_left != '0) && (int'(r_byte_idx) < BUF_DEPTH);
    assign more_next = (left_dec != '0) && (int'(idx_inc) < BUF_DEPTH);
    assign addr_w    = {r_taddr, RW_WRITE};
    assign addr_r    = {r_taddr, RW_READ};
    assign shift_in  = {r_shift[6:0], sda};
    assign rd_addr   = (r_stage == SG_DATA) ? AW'(idx_inc) : AW'(r_byte_idx);
    assign o_q_pop   = pop;

    i2cm_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (AW'(r_fill)),
        .i_wdata (i_q_item.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Decision taken at the end of the current delay period.
    always_comb begin
        act       = ACT_STEP;
        act_val   = rd_data;
        act_stage = SG_DATA;
        act_code  = ST_OK;
        adv_data  = 1'b0;
        case (r_phase)
            PH_START: begin
                if (((r_sub == 2'd0) && !sda) || ((r_sub == 2'd1) && sda)) begin
                    if (r_stage == SG_START1) begin
                        act = ACT_FAIL;
                    end else begin
                        act       = ACT_SEND;
                        act_val   = addr_r;
                        act_stage = SG_ADDRR;
                    end
                end else if (r_sub == 2'd2) begin
                    act = ACT_SEND;
                    if (r_stage == SG_START1) begin
                        act_val   = addr_w;
                        act_stage = SG_ADDRW;
                    end else begin
                        act_val   = addr_r;
                        act_stage = SG_ADDRR;
                    end
                end
            end
            PH_WACK: begin
                if (r_sub == 2'd2) begin
                    case (r_stage)
                        SG_ADDRW: begin
                            if (!sda) begin
                                act       = ACT_SEND;
                                act_val   = r_treg;
                                act_stage = SG_REG;
                            end else begin
                                act      = ACT_STOP;
                                act_code = ST_NACK;
                            end
                        end
                        SG_REG: begin
                            if (r_is_read) begin
                                act = ACT_RESTART;
                            end else if (more_now) begin
                                act = ACT_SEND;
                            end else begin
                                act = ACT_STOP;
                            end
                        end
                        SG_DATA: begin
                            if (sda) begin
                                act      = ACT_STOP;
                                act_code = ST_NACK;
                            end else begin
                                adv_data = 1'b1;
                                act      = more_next ? ACT_SEND : ACT_STOP;
                            end
                        end
                        default: begin
                            act = (r_left != '0) ? ACT_RECV : ACT_STOP;
                        end
                    endcase
                end
            end
            PH_MACK: begin
                if (r_sub == 2'd3) begin
                    act = (left_dec != '0) ? ACT_RECV : ACT_STOP;
                end
            end
            PH_STOP: begin
                if (r_sub == 2'd3) begin
                    act = ACT_FINISH;
                end
            end
            default: begin
                act = ACT_STEP;
            end
        endcase
    end

    // Next state of the phase sequencer.
    always_comb begin
        n_phase = r_phase;
        n_sub   = r_sub;
        n_stage = r_stage;
        if (do_begin) begin
            n_phase = PH_START;
            n_sub   = 2'd0;
            n_stage = SG_START1;
        end else if (do_tick) begin
            case (act)
                ACT_SEND: begin
                    n_phase = PH_SEND;
                    n_sub   = 2'd0;
                    n_stage = act_stage;
                end
                ACT_STOP: begin
                    n_phase = PH_STOP;
                    n_sub   = 2'd0;
                end
                ACT_RECV: begin
                    n_phase = PH_RECV;
                    n_sub   = 2'd0;
                end
                ACT_RESTART: begin
                    n_phase = PH_START;
                    n_sub   = 2'd0;
                    n_stage = SG_START2;
                end
                ACT_FAIL, ACT_FINISH: begin
                    n_phase = PH_IDLE;
                    n_sub   = 2'd0;
                end
                default: begin
                    case (r_phase)
                        PH_SEND: begin
                            if (r_sub == 2'd2) begin
                                n_sub = 2'd0;
                                if (bc_inc == 4'(BYTE_BITS)) begin
                                    n_phase = PH_WACK;
                                end
                            end else begin
                                n_sub = r_sub + 2'd1;
                            end
                        end
                        PH_RECV: begin
                            if (r_sub == 2'd1) begin
                                n_sub = 2'd0;
                                if (bc_inc == 4'(BYTE_BITS)) begin
                                    n_phase = PH_MACK;
                                end
                            end else begin
                                n_sub = 2'd1;
                            end
                        end
                        default: begin
                            n_sub = r_sub + 2'd1;
                        end
                    endcase
                end
            endcase
        end
    end

    // Datapath, bus levels and the result of this transaction.
    always_comb begin
        n_pend     = r_pend;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_byte_idx = r_byte_idx;
        n_left     = r_left;
        n_fill     = r_fill;
        n_taddr    = r_taddr;
        n_treg     = r_treg;
        n_is_read  = r_is_read;
        n_scl      = r_scl;
        n_sda      = r_sda;
        rx_val     = 1'b0;

        if (do_load) begin
            n_fill = r_fill + 1'b1;
        end

        if (do_begin) begin
            n_taddr    = i_q_item.dev_addr;
            n_treg     = i_q_item.reg_addr;
            n_is_read  = (i_q_item.op == OP_READ);
            n_left     = i_q_item.length;
            n_byte_idx = '0;
            n_pend     = ST_OK;
            if (i_q_item.op == OP_WRITE) begin
                n_fill = '0;
            end
        end

        if (do_tick) begin
            case (r_phase)
                PH_START: begin
                    if (r_sub == 2'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b0;
                    end
                end
                PH_SEND: begin
                    case (r_sub)
                        2'd0: n_scl = 1'b0;
                        2'd1: begin
                            n_sda   = r_shift[7];
                            n_shift = {r_shift[6:0], 1'b0};
                        end
                        default: begin
                            n_scl     = 1'b1;
                            n_bit_cnt = (bc_inc == 4'(BYTE_BITS)) ? 4'd0 : bc_inc;
                        end
                    endcase
                end
                PH_WACK: begin
                    case (r_sub)
                        2'd0:    n_scl = 1'b0;
                        2'd1:    n_sda = 1'b1;
                        default: n_scl = 1'b1;
                    endcase
                end
                PH_RECV: begin
                    if (r_sub == 2'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b0;
                    end else begin
                        n_scl   = 1'b1;
                        n_shift = shift_in;
                        if (bc_inc == 4'(BYTE_BITS)) begin
                            rx_val    = 1'b1;
                            n_bit_cnt = 4'd0;
                        end else begin
                            n_bit_cnt = bc_inc;
                        end
                    end
                end
                PH_MACK: begin
                    case (r_sub)
                        2'd0: n_scl = 1'b0;
                        2'd1: n_sda = (r_left == LEN_W'(1));
                        2'd2: n_scl = 1'b1;
                        default: begin
                            n_scl  = 1'b0;
                            n_left = left_dec;
                        end
                    endcase
                end
                PH_STOP: begin
                    case (r_sub)
                        2'd0:    n_scl = 1'b0;
                        2'd1:    n_sda = 1'b0;
                        2'd2:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                default: begin
                    n_scl = r_scl;
                end
            endcase

            case (act)
                ACT_SEND: begin
                    n_shift   = act_val;
                    n_bit_cnt = 4'd0;
                end
                ACT_STOP: n_pend = act_code;
                ACT_RECV: begin
                    n_shift   = 8'd0;
                    n_bit_cnt = 4'd0;
                end
                ACT_FAIL: n_pend = ST_START_FAIL;
                default:  n_pend = n_pend;
            endcase

            if (adv_data) begin
                n_byte_idx = idx_inc;
                n_left     = left_dec;
            end
        end

        n_out.scl_out  = n_scl;
        n_out.sda_out  = n_sda;
        n_out.rx_valid = rx_val;
        n_out.rx_data  = rx_val ? shift_in : 8'd0;
        n_out.busy_res = (n_phase != PH_IDLE);
        n_out.done_res = do_tick && ((act == ACT_FINISH) || (act == ACT_FAIL));
        if (!n_out.done_res) begin
            n_out.status = ST_OK;
        end else if (act == ACT_FAIL) begin
            n_out.status = ST_START_FAIL;
        end else begin
            n_out.status = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_sub       <= 2'd0;
            r_stage     <= SG_START1;
            r_pend      <= ST_OK;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_byte_idx  <= '0;
            r_left      <= '0;
            r_fill      <= '0;
            r_taddr     <= '0;
            r_treg      <= '0;
            r_is_read   <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_sub      <= n_sub;
            r_stage    <= n_stage;
            r_pend     <= n_pend;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_byte_idx <= n_byte_idx;
            r_left     <= n_left;
            r_fill     <= n_fill;
            r_taddr    <= n_taddr;
            r_treg     <= n_treg;
            r_is_read  <= n_is_read;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- hdl/i2cm_checker.sv -----
// Port-level checker for the I2C register-access master, bound to the top level.
`default_nettype none
`include "i2c_master_register_access_defines.svh"

module i2cm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input i2cm_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input i2cm_pkg::t_out_item o_out
);
    import i2cm_pkg::*;

    logic status_known;

    assign status_known = (o_out.status == ST_OK) || (o_out.status == ST_START_FAIL) ||
                          (o_out.status == ST_NACK);

    `I2CM_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `I2CM_ASSERT(a_in_hold, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in), "input moved")
    `I2CM_ASSERT(a_stall_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "held")
    `I2CM_ASSERT(a_done_idle, o_out_valid && o_out.done_res |-> !o_out.busy_res && status_known, "done")
    `I2CM_ASSERT(a_rx_busy, o_out_valid && o_out.rx_valid |-> o_out.busy_res && !o_out.done_res, "rx")

endmodule

bind i2c_master_register_access i2cm_checker u_checker (.*);

`default_nettype wire
